/* rtl/frarms_pkg.sv */
// ----------------------------------------------------------------------------
// frarms_pkg
// Shared types, constants and helpers for the fused residual add and RMS
// normalisation block: widths, fixed-point constants, sequencer states.
// ----------------------------------------------------------------------------
package frarms_pkg;

  // design limits
  localparam int MAX_ROW_LENGTH = 65536;
  localparam int NEWTON_STEPS   = 4;

  // field and datapath widths
  localparam int DATA_W    = 16;
  localparam int SUM_W     = 17;
  localparam int LEN_W     = 17;
  localparam int EPS_W     = 16;
  localparam int CFG_W     = 17;
  localparam int ACC_W     = 50;
  localparam int MS_W      = ACC_W + 1;
  localparam int INV_W     = 32;
  localparam int Y_W       = 32;
  localparam int MUL_W     = 33;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int MAG_W     = 31;
  localparam int K_W       = 5;
  localparam int STEP_W    = $clog2(NEWTON_STEPS + 1);
  localparam int DIV_CNT_W = $clog2(ACC_W);

  // fixed-point constants
  localparam logic [MS_W-1:0]  M_LOW     = MS_W'(2**28);
  localparam logic [MS_W-1:0]  M_HIGH    = MS_W'(2**30);
  localparam logic [29:0]      M_LOW_Q30 = 30'h1000_0000;
  localparam logic [32:0]      THREE_Q30 = 33'h0_C000_0000;
  localparam logic [MUL_W-1:0] RECIP3    = 33'h0_AAAA_AAAB;
  localparam logic [Y_W-1:0]   SEED_TWO  = 32'h8000_0000;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_ROW_LENGTH = 1'b0,
    REG_EPSILON    = 1'b1
  } reg_index_t;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ,
    ST_ACC,
    ST_DIV,
    ST_MS,
    ST_NORM,
    ST_SEED,
    ST_SEED_Y,
    ST_NT_SQ,
    ST_NT_MY,
    ST_NT_F,
    ST_NT_YF,
    ST_NT_Y,
    ST_SCALE,
    ST_NRM_MUL,
    ST_NRM_RND,
    ST_NRM_W,
    ST_NRM_OUT,
    ST_FINISH
  } state_t;

  // magnitude of a 17-bit signed value
  function automatic logic [SUM_W-1:0] abs17(input logic [SUM_W-1:0] v);
    abs17 = v[SUM_W-1] ? (~v + SUM_W'(1)) : v;
  endfunction

  // clamp a 17-bit signed value into Q4.12 range
  function automatic logic [DATA_W-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
    if (v > SUM_W'(32767)) begin
      sat_sum = 16'h7FFF;
    end else if (v < -SUM_W'(32768)) begin
      sat_sum = 16'h8000;
    end else begin
      sat_sum = v[DATA_W-1:0];
    end
  endfunction

  // apply sign to a magnitude and clamp into Q4.12 range
  function automatic logic [DATA_W-1:0] sat_mag(input logic neg,
                                                input logic [MAG_W-1:0] mag);
    if (neg) begin
      if (mag > MAG_W'(32768)) begin
        sat_mag = 16'h8000;
      end else begin
        sat_mag = ~mag[DATA_W-1:0] + 16'd1;
      end
    end else begin
      if (mag > MAG_W'(32767)) begin
        sat_mag = 16'h7FFF;
      end else begin
        sat_mag = mag[DATA_W-1:0];
      end
    end
  endfunction

endpackage

/* rtl/fused_residual_add_rms_norm_top.sv */
// ----------------------------------------------------------------------------
// fused_residual_add_rms_norm_top
// Fused residual add and RMS normalisation of one Q4.12 row in two passes,
// built around a single shared 33x33 multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_ready) carries one element: operation,
//   x_value, residual_value, weight_value and last. Output channel
//   (out_valid/out_ready) returns one result per element: residual_sum,
//   normalized and row_done. Registers row_length and epsilon are written
//   through cfg_write_enable/cfg_index/cfg_data; the user must write them
//   only while the block is idle, as the block does not enforce it.
//   The block works on one element at a time. An accumulate element
//   passes through the square and accumulate states, a normalise element
//   through the multiply, round, weight and output states, as the
//   multiplier is reused for every product. The last accumulate element
//   then adds bit-serial division, a mean-square state, normalising
//   shifts, the seed states, each Newton step and a final scale state.
//   Results sit in an output register, so a stalled receiver does not stop
//   the next element from being taken; only the following result waits.
//   Reset clears the square accumulator and inverse RMS, sets row_length
//   to 4096 and epsilon to 17, and empties the output register.
// ----------------------------------------------------------------------------
module fused_residual_add_rms_norm_top
  import frarms_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // element input
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     operation,
  input  logic signed [DATA_W-1:0] x_value,
  input  logic signed [DATA_W-1:0] residual_value,
  input  logic signed [DATA_W-1:0] weight_value,
  input  logic                     last,
  // result output
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] residual_sum,
  output logic signed [DATA_W-1:0] normalized,
  output logic                     row_done,
  // configuration
  input  logic                     cfg_write_enable,
  input  logic [0:0]               cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  state_t state;
  state_t state_next;

  // configuration and persistent state
  logic [LEN_W-1:0]  row_length;
  logic [EPS_W-1:0]  epsilon;
  logic [ACC_W-1:0]  acc;
  logic [INV_W-1:0]  inv_rms;

  // per-element registers
  logic                     last_r;
  logic [SUM_W-1:0]         sum_mag;
  logic                     sum_neg;
  logic [DATA_W-1:0]        res_r;
  logic [DATA_W-1:0]        w_r;
  logic [DATA_W-1:0]        n16;
  logic [DATA_W-1:0]        norm_r;

  // row-end registers
  logic [ACC_W-1:0]     div_q;
  logic [LEN_W-1:0]     div_rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [MS_W-1:0]      nv;
  logic signed [K_W-1:0] k;
  logic [Y_W-1:0]       y;
  logic [Y_W-1:0]       f;
  logic [STEP_W-1:0]    step;

  // shared multiplier
  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0] prod;

  // combinational helpers
  logic signed [SUM_W-1:0] in_sum;
  logic [LEN_W-1:0]        len;
  logic [ACC_W:0]          acc_sum;
  logic [ACC_W-1:0]        acc_sat;
  logic [LEN_W:0]          rem_sh;
  logic                    rem_ge;
  logic [MS_W-1:0]         ms;
  logic [32:0]             t_val;
  logic signed [K_W:0]     rsh;
  logic [Y_W:0]            scaled;
  logic [ACC_W:0]          rnd1;
  logic [31:0]             rnd2;
  logic                    out_free;
  logic                    in_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // element sum
  assign in_sum = {x_value[DATA_W-1], x_value} + {residual_value[DATA_W-1], residual_value};

  // effective row length
  always_comb begin
    len = row_length;
    if (row_length == '0) begin
      len = LEN_W'(1);
    end else if (int'(row_length) > MAX_ROW_LENGTH) begin
      len = LEN_W'(MAX_ROW_LENGTH);
    end
  end

  // saturating accumulate of the square
  assign acc_sum = {1'b0, acc} + (ACC_W+1)'(prod[32:0]);
  assign acc_sat = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];

  // one restoring division step
  assign rem_sh = {div_rem, div_q[ACC_W-1]};
  assign rem_ge = rem_sh >= {1'b0, len};

  // mean square plus epsilon
  assign ms = MS_W'(div_q) + MS_W'(epsilon);

  // newton correction term
  assign t_val = prod[62:30];

  // final scale to Q12.20
  assign rsh = {k[K_W-1], k} + (K_W+1)'(13);
  always_comb begin
    if (rsh < 0) begin
      scaled = {y, 1'b0};
    end else begin
      scaled = {1'b0, y} >> rsh[K_W-1:0];
    end
  end

  // rounding of the normalise products
  assign rnd1 = {1'b0, prod[ACC_W-1:0]} + (ACC_W+1)'(2**19);
  assign rnd2 = prod[31:0] + 32'd2048;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          state_next = operation ? ST_NRM_MUL : ST_SQ;
        end
      end
      ST_SQ:      state_next = ST_ACC;
      ST_ACC:     state_next = last_r ? ST_DIV : ST_FINISH;
      ST_DIV: begin
        if (div_cnt == DIV_CNT_W'(ACC_W - 1)) begin
          state_next = ST_MS;
        end
      end
      ST_MS:      state_next = (ms == '0) ? ST_FINISH : ST_NORM;
      ST_NORM: begin
        if (nv >= M_HIGH || nv < M_LOW) begin
          state_next = ST_NORM;
        end else begin
          state_next = ST_SEED;
        end
      end
      ST_SEED:    state_next = ST_SEED_Y;
      ST_SEED_Y:  state_next = ST_NT_SQ;
      ST_NT_SQ:   state_next = ST_NT_MY;
      ST_NT_MY:   state_next = ST_NT_F;
      ST_NT_F:    state_next = ST_NT_YF;
      ST_NT_YF:   state_next = ST_NT_Y;
      ST_NT_Y: begin
        state_next = (step == STEP_W'(NEWTON_STEPS - 1)) ? ST_SCALE : ST_NT_SQ;
      end
      ST_SCALE:   state_next = ST_FINISH;
      ST_NRM_MUL: state_next = ST_NRM_RND;
      ST_NRM_RND: state_next = ST_NRM_W;
      ST_NRM_W:   state_next = ST_NRM_OUT;
      ST_NRM_OUT: state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake and multiplier operand select
  always_comb begin
    in_ready = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_SQ: begin
        mul_a = MUL_W'(sum_mag);
        mul_b = MUL_W'(sum_mag);
      end
      ST_SEED: begin
        mul_a = MUL_W'({nv[29:0] - M_LOW_Q30, 2'b00});
        mul_b = RECIP3;
      end
      ST_NT_SQ: begin
        mul_a = MUL_W'(y);
        mul_b = MUL_W'(y);
      end
      ST_NT_MY: begin
        mul_a = MUL_W'(nv[29:0]);
        mul_b = prod[62:30];
      end
      ST_NT_YF: begin
        mul_a = MUL_W'(y);
        mul_b = MUL_W'(f);
      end
      ST_NRM_MUL: begin
        mul_a = MUL_W'(sum_mag);
        mul_b = MUL_W'(inv_rms);
      end
      ST_NRM_W: begin
        mul_a = MUL_W'(abs17({n16[DATA_W-1], n16}));
        mul_b = MUL_W'(abs17({w_r[DATA_W-1], w_r}));
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // shared multiplier with registered product
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= LEN_W'(4096);
      epsilon    <= EPS_W'(17);
    end else if (cfg_write_enable) begin
      unique case (reg_index_t'(cfg_index))
        REG_ROW_LENGTH: row_length <= cfg_data[LEN_W-1:0];
        REG_EPSILON:    epsilon    <= cfg_data[EPS_W-1:0];
        default:        row_length <= row_length;
      endcase
    end
  end

  // accumulator and inverse rms
  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      inv_rms <= '0;
    end else begin
      if (state == ST_ACC) begin
        acc <= last_r ? '0 : acc_sat;
      end
      if (state == ST_MS && ms == '0) begin
        inv_rms <= '1;
      end else if (state == ST_SCALE) begin
        inv_rms <= scaled[Y_W] ? '1 : scaled[Y_W-1:0];
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          sum_mag <= abs17(in_sum);
          sum_neg <= in_sum[SUM_W-1];
          res_r   <= sat_sum(in_sum);
          last_r  <= last;
          w_r     <= weight_value;
        end
      end
      ST_ACC: begin
        norm_r  <= '0;
        div_q   <= acc_sat;
        div_rem <= '0;
        div_cnt <= '0;
      end
      ST_DIV: begin
        div_rem <= rem_ge ? LEN_W'(rem_sh - {1'b0, len}) : rem_sh[LEN_W-1:0];
        div_q   <= {div_q[ACC_W-2:0], rem_ge};
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end
      ST_MS: begin
        nv <= ms;
        k  <= '0;
      end
      ST_NORM: begin
        if (nv >= M_HIGH) begin
          nv <= nv >> 2;
          k  <= k + K_W'(1);
        end else if (nv < M_LOW) begin
          nv <= nv << 2;
          k  <= k - K_W'(1);
        end
      end
      ST_SEED_Y: begin
        y    <= SEED_TWO - prod[64:33];
        step <= '0;
      end
      ST_NT_F: begin
        f <= (t_val >= THREE_Q30) ? '0 : Y_W'(THREE_Q30 - t_val);
      end
      ST_NT_Y: begin
        y    <= prod[62:31];
        step <= step + STEP_W'(1);
      end
      ST_NRM_RND: begin
        n16 <= sat_mag(sum_neg, rnd1[ACC_W:20]);
      end
      ST_NRM_OUT: begin
        norm_r <= sat_mag(n16[DATA_W-1] ^ w_r[DATA_W-1], MAG_W'(rnd2[31:12]));
      end
      default: begin
        f <= f;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      residual_sum <= res_r;
      normalized   <= norm_r;
      row_done     <= last_r;
    end
  end

endmodule

/* rtl/frarms_check.sv */
// ----------------------------------------------------------------------------
// frarms_check
// Port-level checks for the fused residual add and RMS normalisation block,
// attached to the top level by a bind statement.
// ----------------------------------------------------------------------------
module frarms_check (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] residual_sum,
  input logic [15:0] normalized,
  input logic        row_done
);

  // output register is empty after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // one element at a time: no input transfer right after one
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while busy");

  // no result can appear in the cycle after an input transfer
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result too early after input transfer");

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(residual_sum)
      && $stable(normalized) && $stable(row_done))
    else $error("stalled result changed");

endmodule

bind fused_residual_add_rms_norm_top frarms_check u_frarms_check (.*);
